// ===== sv/mfr_pkg.sv =====
// Shared types, constants and helpers for the marker frame receiver.
`default_nettype none
package mfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned PCNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned FLEN_W = 9;
  localparam logic [7:0] IDLE_FILL = 8'hAA;

  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END = 2'd1;
  localparam logic [1:0] REG_SILENCE = 2'd2;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic [1:0] ST_GOOD = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;
  localparam logic [1:0] ST_SILENT = 2'd3;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [15:0] silence_limit;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    logic [1:0]        status;
    logic              last;
    logic [FLEN_W-1:0] frame_length;
    logic [15:0]       lost_count;
    logic [15:0]       error_count;
    logic [15:0]       frame_count;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mfr_if.sv =====
// Request channel interfaces for received items and results.
`default_nettype none
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface mfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       last;
  logic [8:0] frame_length;
  logic [15:0] lost_count;
  logic [15:0] error_count;
  logic [15:0] frame_count;
  modport source (output valid, output kind, output data_byte, output status, output last,
                  output frame_length, output lost_count, output error_count,
                  output frame_count, input ready);
  modport sink (input valid, input kind, input data_byte, input status, input last,
                input frame_length, input lost_count, input error_count,
                input frame_count, output ready);
endinterface
`default_nettype wire

// ===== sv/mfr_regs.sv =====
// APB configuration registers: markers and silence limit.
`default_nettype none
module mfr_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mfr_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output mfr_pkg::cfg_t                   cfg
);
  import mfr_pkg::*;

  logic [1:0] idx;
  logic       wr;

  assign idx = paddr[3:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= 8'h10;
      cfg.end_marker <= 8'h03;
      cfg.silence_limit <= 16'd100;
    end else if (wr) begin
      unique case (idx)
        REG_START: cfg.start_marker <= pwdata[7:0];
        REG_END: cfg.end_marker <= pwdata[7:0];
        REG_SILENCE: cfg.silence_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START: prdata = {24'd0, cfg.start_marker};
      REG_END: prdata = {24'd0, cfg.end_marker};
      REG_SILENCE: prdata = {16'd0, cfg.silence_limit};
      default: prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/mfr_core.sv =====
// Input register and deframing state update; produces up to two results per item.
`default_nettype none
module mfr_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mfr_pkg::cfg_t cfg,
  input  wire logic          space_ok,
  mfr_in_if.sink             rx_in,
  output mfr_pkg::push_t     push
);
  import mfr_pkg::*;

  typedef enum logic [2:0] {PH_IDLE, PH_ONE, PH_BODY, PH_ESC, PH_END} phase_t;

  phase_t            phase, phase_next;
  logic [7:0]        running_xor, running_xor_next;
  logic [7:0]        byte_counter, byte_counter_next;
  logic [PCNT_W-1:0] payload_count, payload_count_next;
  logic [15:0]       silence_ticks, silence_ticks_next;
  logic [15:0]       lost_total, lost_total_next;
  logic [15:0]       error_total, error_total_next;
  logic [15:0]       frame_total, frame_total_next;

  logic       stage_v;
  logic       stage_func;
  logic [7:0] stage_byte;
  logic       go;
  logic       accept;

  logic [1:0]        n;
  logic              k0, k1;
  logic [7:0]        d0, d1;
  logic [1:0]        s0;
  logic [PCNT_W-1:0] l0;
  logic [PCNT_W:0]   pc_plus2;
  logic [7:0]        ch;

  assign go = stage_v && space_ok;
  assign rx_in.ready = !stage_v || space_ok;
  assign accept = rx_in.valid && rx_in.ready;
  assign ch = stage_byte;
  assign pc_plus2 = {1'b0, payload_count} + (PCNT_W+1)'(2);

  always_comb begin
    phase_next = phase;
    running_xor_next = running_xor;
    byte_counter_next = byte_counter;
    payload_count_next = payload_count;
    silence_ticks_next = silence_ticks;
    lost_total_next = lost_total;
    error_total_next = error_total;
    frame_total_next = frame_total;
    n = 2'd0;
    k0 = KIND_DATA;
    k1 = KIND_DATA;
    d0 = 8'd0;
    d1 = 8'd0;
    s0 = ST_GOOD;
    l0 = '0;
    if (stage_func == FUNC_TICK) begin
      silence_ticks_next = sat_inc16(silence_ticks);
      if (phase != PH_IDLE && silence_ticks_next > cfg.silence_limit) begin
        if (phase != PH_ONE) begin
          n = 2'd1; k0 = KIND_END; s0 = ST_SILENT; l0 = payload_count;
        end
        phase_next = PH_IDLE;
      end
    end else begin
      silence_ticks_next = 16'd0;
      byte_counter_next = byte_counter + 8'd1;
      unique case (phase)
        PH_IDLE: begin
          if (ch == cfg.start_marker) phase_next = PH_ONE;
          else if (ch != IDLE_FILL) lost_total_next = sat_inc16(lost_total);
        end
        PH_ONE: begin
          if (ch == cfg.start_marker) begin
            phase_next = PH_BODY;
            running_xor_next = 8'd0;
            payload_count_next = '0;
            byte_counter_next = 8'd2;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_BODY: begin
          running_xor_next = running_xor ^ ch;
          if (ch == cfg.start_marker) begin
            phase_next = PH_ESC;
          end else if (payload_count >= PCNT_W'(MAX_PAYLOAD)) begin
            error_total_next = sat_inc16(error_total);
            n = 2'd1; k0 = KIND_END; s0 = ST_LONG; l0 = payload_count;
            phase_next = PH_IDLE;
          end else begin
            n = 2'd1; d0 = ch;
            payload_count_next = payload_count + PCNT_W'(1);
          end
        end
        PH_ESC: begin
          running_xor_next = running_xor ^ ch;
          if (ch == cfg.end_marker) begin
            phase_next = PH_END;
          end else if (pc_plus2 > (PCNT_W+1)'(MAX_PAYLOAD)) begin
            error_total_next = sat_inc16(error_total);
            n = 2'd1; k0 = KIND_END; s0 = ST_LONG; l0 = payload_count;
            phase_next = PH_IDLE;
          end else begin
            n = 2'd2; d0 = cfg.start_marker; d1 = ch;
            payload_count_next = pc_plus2[PCNT_W-1:0];
            phase_next = PH_BODY;
          end
        end
        PH_END: begin
          frame_total_next = frame_total + 16'd1;
          n = 2'd1; k0 = KIND_END; l0 = payload_count;
          if ((running_xor ^ byte_counter_next) == ch) begin
            s0 = ST_GOOD;
          end else begin
            s0 = ST_CSUM;
            error_total_next = sat_inc16(error_total);
          end
          phase_next = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    push.n = go ? n : 2'd0;
    push.r0.kind = k0;
    push.r0.data_byte = d0;
    push.r0.status = s0;
    push.r0.last = (n == 2'd1);
    push.r0.frame_length = FLEN_W'(l0);
    push.r0.lost_count = lost_total_next;
    push.r0.error_count = error_total_next;
    push.r0.frame_count = frame_total_next;
    push.r1.kind = k1;
    push.r1.data_byte = d1;
    push.r1.status = ST_GOOD;
    push.r1.last = 1'b1;
    push.r1.frame_length = '0;
    push.r1.lost_count = lost_total_next;
    push.r1.error_count = error_total_next;
    push.r1.frame_count = frame_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
      phase <= PH_IDLE;
      running_xor <= 8'd0;
      byte_counter <= 8'd0;
      payload_count <= '0;
      silence_ticks <= 16'd0;
      lost_total <= 16'd0;
      error_total <= 16'd0;
      frame_total <= 16'd0;
    end else begin
      if (accept) stage_v <= 1'b1;
      else if (go) stage_v <= 1'b0;
      if (go) begin
        phase <= phase_next;
        running_xor <= running_xor_next;
        byte_counter <= byte_counter_next;
        payload_count <= payload_count_next;
        silence_ticks <= silence_ticks_next;
        lost_total <= lost_total_next;
        error_total <= error_total_next;
        frame_total <= frame_total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_func <= rx_in.func;
      stage_byte <= rx_in.rx_byte;
    end
  end
endmodule
`default_nettype wire

// ===== sv/mfr_outq.sv =====
// Four-entry result queue taking up to two results per cycle.
`default_nettype none
module mfr_outq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mfr_pkg::push_t push,
  output logic                space_ok,
  mfr_out_if.source           res_out
);
  import mfr_pkg::*;

  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;
  result_t    head;

  assign space_ok = (count <= 3'd2);
  assign pop = res_out.valid && res_out.ready;
  assign head = mem[rd_ptr];

  assign res_out.valid = (count != 3'd0);
  assign res_out.kind = head.kind;
  assign res_out.data_byte = head.data_byte;
  assign res_out.status = head.status;
  assign res_out.last = head.last;
  assign res_out.frame_length = head.frame_length;
  assign res_out.lost_count = head.lost_count;
  assign res_out.error_count = head.error_count;
  assign res_out.frame_count = head.frame_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.n;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push.n} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.n == 2'd2) mem[wr_ptr + 2'd1] <= push.r1;
  end
endmodule
`default_nettype wire

// ===== sv/marker_frame_receiver_xor_check_unit.sv =====
// Top level of the marker frame receiver with XOR checksum.
// Takes one received byte or time tick per cycle. Each item sits in an input
// register while the deframing state is updated, and its results go into a
// four-entry queue that drives the result channel. An item that releases an
// escaped start marker pair yields two results; the result channel delivers
// one result per cycle while ready is high. Input is held back only while the
// queue has fewer than two free entries. Configuration goes over the APB port.
`default_nettype none
module marker_frame_receiver_xor_check_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  mfr_in_if.sink                          rx_in,
  mfr_out_if.source                       res_out,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mfr_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import mfr_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  space_ok;

  mfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mfr_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .space_ok (space_ok),
    .rx_in    (rx_in),
    .push     (push)
  );

  mfr_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .res_out  (res_out)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> space_ok)
    else $error("result push without queue room");

  a_pair_is_data: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (push.r0.kind == KIND_DATA && push.r1.kind == KIND_DATA))
    else $error("two results from one item must both be payload");

  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && res_out.kind == KIND_END) |-> (res_out.data_byte == 8'd0))
    else $error("frame end report carries data");

  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !res_out.valid)
    else $error("result valid right after reset");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_marker_frame_receiver_xor_check_unit.sv =====
`timescale 1ns / 1ps
// Testbench for the marker frame receiver: directed table, random framed traffic, predictor check.
module tb_marker_frame_receiver_xor_check_unit;
  import mfr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ANY_COUNT = -1;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef enum logic [2:0] {LINE_IDLE, LINE_OPEN1, LINE_BODY, LINE_ESC, LINE_CSUM} line_state_t;

  typedef struct {
    logic       func;
    logic [7:0] data;
    int         n;
    logic [1:0] st;
    int         flen;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mfr_in_if rx_if();
  mfr_out_if res_if();

  marker_frame_receiver_xor_check_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .rx_in   (rx_if),
    .res_out (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // deframer shadow state
  logic [7:0]  cfg_start = 8'h10;
  logic [7:0]  cfg_end = 8'h03;
  logic [15:0] cfg_silence = 16'd100;
  line_state_t line_state = LINE_IDLE;
  logic [7:0]  frame_xor = '0;
  logic [7:0]  byte_seq = '0;
  logic [8:0]  payload_len = '0;
  logic [15:0] silent_ticks = '0;
  logic [15:0] lost_total = '0;
  logic [15:0] error_total = '0;
  logic [15:0] frame_total = '0;

  result_t pending_results[$];
  stim_t   in_flight[$];
  stim_t   stim_q[$];
  int      mismatch_count = 0;
  int      idle_level = 0;
  int      stall_level = 0;
  int      stall_left = 0;
  int      cycle_count = 0;

  stim_t dir_tab[25] = '{
    '{FUNC_BYTE, 8'h55, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'hAA, 0, ST_GOOD, 0},
    '{FUNC_TICK, 8'hFF, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h22, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h00, ANY_COUNT, ST_GOOD, 0},
    '{FUNC_BYTE, 8'hFF, ANY_COUNT, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h41, ANY_COUNT, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h03, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'hB4, 1, ST_GOOD, 4},
    '{FUNC_TICK, 8'h00, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h5A, ANY_COUNT, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h03, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h00, 1, ST_CSUM, 1},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, 0, ST_GOOD, 0},
    '{FUNC_BYTE, 8'h10, ANY_COUNT, ST_GOOD, 0}
  };

  function automatic logic [15:0] bump16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // advances the shadow deframer by one item and queues the results it causes
  function automatic int deframe_step(logic func, logic [7:0] b);
    result_t res[2];
    int n;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (func == FUNC_TICK) begin
      silent_ticks = bump16(silent_ticks);
      if (line_state != LINE_IDLE && silent_ticks > cfg_silence) begin
        if (line_state != LINE_OPEN1) begin
          res[n].kind = KIND_END;
          res[n].status = ST_SILENT;
          res[n].frame_length = payload_len;
          n++;
        end
        line_state = LINE_IDLE;
      end
    end else begin
      silent_ticks = '0;
      byte_seq = byte_seq + 8'd1;
      case (line_state)
        LINE_IDLE: begin
          if (b == cfg_start) line_state = LINE_OPEN1;
          else if (b != IDLE_FILL) lost_total = bump16(lost_total);
        end
        LINE_OPEN1: begin
          if (b == cfg_start) begin
            line_state = LINE_BODY;
            frame_xor = '0;
            payload_len = '0;
            byte_seq = 8'd2;
          end else begin
            line_state = LINE_IDLE;
          end
        end
        LINE_BODY: begin
          frame_xor ^= b;
          if (b == cfg_start) begin
            line_state = LINE_ESC;
          end else if (payload_len >= MAX_PAYLOAD) begin
            error_total = bump16(error_total);
            res[n].kind = KIND_END;
            res[n].status = ST_LONG;
            res[n].frame_length = payload_len;
            n++;
            line_state = LINE_IDLE;
          end else begin
            res[n].kind = KIND_DATA;
            res[n].data_byte = b;
            n++;
            payload_len++;
          end
        end
        LINE_ESC: begin
          frame_xor ^= b;
          if (b == cfg_end) begin
            line_state = LINE_CSUM;
          end else if (int'(payload_len) + 2 > MAX_PAYLOAD) begin
            error_total = bump16(error_total);
            res[n].kind = KIND_END;
            res[n].status = ST_LONG;
            res[n].frame_length = payload_len;
            n++;
            line_state = LINE_IDLE;
          end else begin
            res[0].kind = KIND_DATA;
            res[0].data_byte = cfg_start;
            res[1].kind = KIND_DATA;
            res[1].data_byte = b;
            n = 2;
            payload_len += 9'd2;
            line_state = LINE_BODY;
          end
        end
        default: begin
          frame_total = frame_total + 16'd1;
          res[n].kind = KIND_END;
          res[n].frame_length = payload_len;
          if ((frame_xor ^ byte_seq) == b) begin
            res[n].status = ST_GOOD;
          end else begin
            res[n].status = ST_CSUM;
            error_total = bump16(error_total);
          end
          n++;
          line_state = LINE_IDLE;
        end
      endcase
    end
    for (int k = 0; k < n; k++) begin
      res[k].lost_count = lost_total;
      res[k].error_count = error_total;
      res[k].frame_count = frame_total;
      res[k].last = (k == n - 1);
      pending_results.push_back(res[k]);
    end
    return n;
  endfunction

  always @(posedge clk) begin
    stim_t it;
    result_t want;
    int n;
    if (rst) begin
      res_if.ready <= 1'b1;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        it = in_flight.pop_front();
        n = deframe_step(rx_if.func, rx_if.rx_byte);
        if (it.n != ANY_COUNT) begin
          field_check("table result count", it.n, n);
          if (n == it.n && n > 0) begin
            want = pending_results[$];
            field_check("table kind", KIND_END, want.kind);
            field_check("table status", it.st, want.status);
            field_check("table frame_length", it.flen, want.frame_length);
          end
        end
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result request with nothing pending");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          field_check("kind", want.kind, res_if.kind);
          field_check("data_byte", want.data_byte, res_if.data_byte);
          field_check("status", want.status, res_if.status);
          field_check("last", want.last, res_if.last);
          field_check("frame_length", want.frame_length, res_if.frame_length);
          field_check("lost_count", want.lost_count, res_if.lost_count);
          field_check("error_count", want.error_count, res_if.error_count);
          field_check("frame_count", want.frame_count, res_if.frame_count);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) res_if.ready <= 1'b1;
      end else if (stall_level != 0 && $urandom_range(0, stall_level == 1 ? 15 : 4) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(stim_t it);
    rx_if.valid <= 1'b1;
    rx_if.func <= it.func;
    rx_if.rx_byte <= it.data;
    in_flight.push_back(it);
    do @(posedge clk); while (!rx_if.ready);
    if (idle_level != 0 && $urandom_range(0, idle_level == 1 ? 7 : 2) == 0) begin
      rx_if.valid <= 1'b0;
      rx_if.func <= 1'($urandom_range(0, 1));
      rx_if.rx_byte <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_START: cfg_start = value[7:0];
      REG_END: cfg_end = value[7:0];
      REG_SILENCE: cfg_silence = value[15:0];
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_START: want = {24'd0, cfg_start};
      REG_END: want = {24'd0, cfg_end};
      default: want = {16'd0, cfg_silence};
    endcase
    if (idx != REG_NONE) field_check("prdata", want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic void add_byte(logic [7:0] b);
    stim_t s;
    s.func = FUNC_BYTE;
    s.data = b;
    s.n = ANY_COUNT;
    s.st = ST_GOOD;
    s.flen = 0;
    stim_q.push_back(s);
  endfunction

  function automatic void add_ticks(int count);
    stim_t s;
    s.func = FUNC_TICK;
    s.n = ANY_COUNT;
    s.st = ST_GOOD;
    s.flen = 0;
    for (int k = 0; k < count; k++) begin
      s.data = 8'($urandom_range(0, 255));
      stim_q.push_back(s);
    end
  endfunction

  // mostly well-formed frames with random content, plus noise, lone markers and cut frames
  task automatic build_traffic(int n_items, bit long_ok);
    int pick;
    int len;
    int i;
    logic [7:0] x;
    logic [7:0] seq;
    logic [7:0] b;
    stim_q.delete();
    while (stim_q.size() < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 4))
          add_byte($urandom_range(0, 1) ? IDLE_FILL : 8'($urandom_range(0, 255)));
      end else if (pick < 15) begin
        add_byte(cfg_start);
        if (cfg_silence <= 40) add_ticks(int'(cfg_silence) + 1);
        else add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte(cfg_start);
        add_byte(cfg_start);
        x = '0;
        seq = 8'd2;
        len = (long_ok && $urandom_range(0, 11) == 0) ? $urandom_range(250, 258)
                                                       : $urandom_range(0, 12);
        i = 0;
        while (i < len) begin
          b = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 5) == 0) begin
            add_byte(cfg_start);
            add_byte(b);
            x ^= cfg_start ^ b;
            seq += 8'd2;
            i += 2;
          end else begin
            add_byte(b);
            x ^= b;
            seq += 8'd1;
            i++;
          end
          if ($urandom_range(0, 19) == 0) add_ticks($urandom_range(1, 3));
        end
        if (cfg_silence <= 40 && $urandom_range(0, 9) == 0) begin
          add_ticks(int'(cfg_silence) + 1);
        end else begin
          add_byte(cfg_start);
          add_byte(cfg_end);
          x ^= cfg_start ^ cfg_end;
          seq += 8'd3;
          add_byte($urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255)) : x ^ seq);
        end
      end
    end
  endtask

  task automatic run_phase(logic [7:0] sm, logic [7:0] em, logic [15:0] lim, bit long_ok,
                           int send_idle, int recv_idle, int n_items);
    int half;
    wait_drained();
    apb_write(REG_START, {24'($urandom), sm});
    apb_write(REG_END, {24'($urandom), em});
    apb_write(REG_SILENCE, {16'($urandom), lim});
    apb_write(REG_NONE, $urandom);
    idle_level = send_idle;
    stall_level = recv_idle;
    build_traffic(n_items, long_ok);
    half = stim_q.size() / 2;
    foreach (stim_q[i]) begin
      if (i == half) wait_drained();
      send_item(stim_q[i]);
    end
  endtask

  initial begin
    rx_if.valid <= 1'b0;
    rx_if.func <= FUNC_BYTE;
    rx_if.rx_byte <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_level = 1;
    stall_level = 1;
    foreach (dir_tab[k]) send_item(dir_tab[k]);
    run_phase(8'h00, 8'hFF, 16'd1, 1'b0, 2, 2, 150);
    run_phase(8'hFF, 8'h00, 16'hFFFF, 1'b1, 1, 1, 150);
    run_phase(8'h7E, 8'h7D, 16'd3, 1'b0, 2, 0, 150);
    run_phase(8'($urandom), 8'($urandom), 16'($urandom_range(2, 20)), 1'b1, 1, 2, 150);
    run_phase(8'h5C, 8'h5C, 16'd5, 1'b0, 0, 1, 120);
    run_phase(8'($urandom), 8'($urandom), 16'($urandom_range(1, 30)), 1'b0, 0, 0, 120);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
